// ----- design/hec_pkg.sv -----
package hec_pkg;

    localparam int ByteW = 8;
    localparam int RegW = 64;
    localparam int AddrW = 6;
    localparam int RegIdxW = 3;
    localparam int MaxRes = 3;
    localparam int CntW = 2;

    // Register indexes on the configuration port.
    localparam logic [RegIdxW-1:0] RegDirection = 3'd0;
    localparam logic [RegIdxW-1:0] RegEscChar = 3'd1;
    localparam logic [RegIdxW-1:0] RegMask0 = 3'd2;
    localparam logic [RegIdxW-1:0] RegMask1 = 3'd3;
    localparam logic [RegIdxW-1:0] RegMask2 = 3'd4;
    localparam logic [RegIdxW-1:0] RegMask3 = 3'd5;

    localparam logic DirEncode = 1'b0;
    localparam logic DirDecode = 1'b1;

    localparam logic [ByteW-1:0] EscCharReset = 8'd92;
    localparam logic [RegW-1:0] Mask0Reset = 64'h0000_0001_0000_0401;
    localparam logic [RegW-1:0] Mask1Reset = 64'h0000_0000_1000_0000;
    localparam logic [RegW-1:0] Mask2Reset = 64'h0;
    localparam logic [RegW-1:0] Mask3Reset = 64'h0;

    // Decode position within an escape.
    localparam logic [1:0] PhIdle = 2'd0;
    localparam logic [1:0] PhHigh = 2'd1;
    localparam logic [1:0] PhLow = 2'd2;

    typedef struct packed {
        logic [ByteW-1:0] in_byte;
        logic             in_last;
    } t_in;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             run_last;
        logic             value_last;
    } t_out;

    typedef struct packed {
        logic             direction;
        logic [ByteW-1:0] escape_char;
        logic [4*RegW-1:0] mask;
    } t_cfg;

    function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
        logic [ByteW-1:0] d;
        if (nib < 4'd10) begin
            d = 8'h30 + {4'd0, nib};
        end else begin
            d = 8'h37 + {4'd0, nib};
        end
        return d;
    endfunction

    function automatic logic [3:0] digit_value(input logic [ByteW-1:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

endpackage

// ----- design/hec_regs.sv -----
module hec_regs
    import hec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [RegW-1:0]     pwdata,
    output logic [RegW-1:0]     prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    logic             r_direction;
    logic [ByteW-1:0] r_esc_char;
    logic [RegW-1:0]  r_mask [4];
    logic [RegIdxW-1:0] idx;
    logic             wr_en;

    assign idx = paddr[AddrW-1:AddrW-RegIdxW];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DirEncode;
            r_esc_char <= EscCharReset;
            r_mask[0] <= Mask0Reset;
            r_mask[1] <= Mask1Reset;
            r_mask[2] <= Mask2Reset;
            r_mask[3] <= Mask3Reset;
        end else if (wr_en) begin
            case (idx)
                RegDirection: r_direction <= pwdata[0];
                RegEscChar:   r_esc_char <= pwdata[ByteW-1:0];
                RegMask0:     r_mask[0] <= pwdata;
                RegMask1:     r_mask[1] <= pwdata;
                RegMask2:     r_mask[2] <= pwdata;
                RegMask3:     r_mask[3] <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            RegDirection: prdata = {{(RegW-1){1'b0}}, r_direction};
            RegEscChar:   prdata = {{(RegW-ByteW){1'b0}}, r_esc_char};
            RegMask0:     prdata = r_mask[0];
            RegMask1:     prdata = r_mask[1];
            RegMask2:     prdata = r_mask[2];
            RegMask3:     prdata = r_mask[3];
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.direction = r_direction;
    assign o_cfg.escape_char = r_esc_char;
    assign o_cfg.mask = {r_mask[3], r_mask[2], r_mask[1], r_mask[0]};

endmodule

// ----- design/hec_core.sv -----
module hec_core
    import hec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_high, n_high;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [MaxRes-1:0][ByteW-1:0] r_bytes, n_bytes;
    logic        r_vlast;
    logic        accept;
    logic        take;
    logic [3:0]  dv;
    logic        flagged;

    assign o_out_valid = (r_cnt != '0);
    assign take = o_out_valid && i_out_ready;
    // The result buffer may be refilled in the cycle its final byte is taken.
    assign o_in_ready = (r_cnt == '0) || (r_cnt == CntW'(1) && i_out_ready);
    assign accept = i_in_valid && o_in_ready;

    assign dv = digit_value(i_in.in_byte);
    assign flagged = i_cfg.mask[i_in.in_byte];

    always_comb begin
        n_phase = r_phase;
        n_high = r_high;
        n_cnt = '0;
        n_bytes = '0;
        if (i_cfg.direction == DirEncode) begin
            n_phase = PhIdle;
            n_high = 4'd0;
            if (flagged) begin
                n_cnt = CntW'(3);
                n_bytes[0] = i_cfg.escape_char;
                n_bytes[1] = hex_digit(i_in.in_byte[7:4]);
                n_bytes[2] = hex_digit(i_in.in_byte[3:0]);
            end else begin
                n_cnt = CntW'(1);
                n_bytes[0] = i_in.in_byte;
            end
        end else begin
            case (r_phase)
                PhHigh: begin
                    n_high = dv;
                    if (i_in.in_last) begin
                        // Value ended before the low digit: it counts as zero.
                        n_phase = PhIdle;
                        n_cnt = CntW'(1);
                        n_bytes[0] = {dv, 4'd0};
                    end else begin
                        n_phase = PhLow;
                    end
                end
                PhLow: begin
                    n_phase = PhIdle;
                    n_cnt = CntW'(1);
                    n_bytes[0] = {r_high, dv};
                end
                default: begin
                    n_phase = PhIdle;
                    if (i_in.in_byte == i_cfg.escape_char) begin
                        if (i_in.in_last) begin
                            n_cnt = CntW'(1);
                        end else begin
                            n_phase = PhHigh;
                            n_high = 4'd0;
                        end
                    end else begin
                        n_cnt = CntW'(1);
                        n_bytes[0] = i_in.in_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhIdle;
            r_high <= 4'd0;
            r_cnt <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_high <= n_high;
            r_cnt <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bytes <= n_bytes;
            r_vlast <= i_in.in_last;
        end else if (take) begin
            r_bytes[0] <= r_bytes[1];
            r_bytes[1] <= r_bytes[2];
        end
    end

    assign o_out.out_byte = r_bytes[0];
    assign o_out.run_last = (r_cnt == CntW'(1));
    assign o_out.value_last = (r_cnt == CntW'(1)) && r_vlast;

endmodule

// ----- design/hex_escape_codec.sv -----
// A request's first result, if any, is registered and shown in the cycle
// after it is accepted. One request per cycle unless the output stalls; an
// escaped encode byte holds the input while its three result bytes drain.
// Reset (synchronous, active low) restores the register defaults, leaves the
// decoder outside any escape and empties the result buffer.
module hex_escape_codec
    import hec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [RegW-1:0]  pwdata,
    output logic [RegW-1:0]  prdata,
    output logic             pready,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out
);

    t_cfg cfg;

    hec_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- design/hec_chk.sv -----
module hec_chk
    import hec_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // A stalled result stays on offer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("stalled result changed");

    // The end of a value is always the end of its request's results.
    a_vlast_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.value_last |-> o_out.run_last)
        else $error("value end flagged on a result that is not the last of its request");

    // While bytes of an expansion remain, no new request may be taken.
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.run_last |-> !o_in_ready)
        else $error("request accepted while an expansion was still draining");

endmodule

bind hex_escape_codec hec_chk u_hec_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
